[hw/rtl/solpq_pkg.sv]
// Shared types and codes of the sorted open list priority queue.
`default_nettype none
package solpq_pkg;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_PUSH  = 3'd1;
  localparam logic [2:0] OP_LOWER = 3'd2;
  localparam logic [2:0] OP_RAISE = 3'd3;
  localparam logic [2:0] OP_FIND  = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_HNDL = 2'd2;

  typedef enum logic [2:0] {
    K_NOP,
    K_CLEAR,
    K_PUSH,
    K_LOWER,
    K_RAISE,
    K_FIND
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] key;
    logic [7:0]  handle;
    logic [31:0] cost;
    logic        closed;
  } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/solpq_front.sv]
// Front end: accepts input items and classifies the operation code.
`default_nettype none
module solpq_front (
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [2:0]     in_operation,
  input  wire logic [31:0]    in_key,
  input  wire logic [7:0]     in_handle,
  input  wire logic [31:0]    in_cost,
  input  wire logic           in_closed,
  output logic                cmd_valid,
  input  wire logic           cmd_ready,
  output solpq_pkg::cmd_t     cmd
);

  solpq_pkg::kind_t kind;

  always_comb begin
    unique case (in_operation)
      solpq_pkg::OP_CLEAR: kind = solpq_pkg::K_CLEAR;
      solpq_pkg::OP_PUSH:  kind = solpq_pkg::K_PUSH;
      solpq_pkg::OP_LOWER: kind = solpq_pkg::K_LOWER;
      solpq_pkg::OP_RAISE: kind = solpq_pkg::K_RAISE;
      solpq_pkg::OP_FIND:  kind = solpq_pkg::K_FIND;
      default:             kind = solpq_pkg::K_NOP;
    endcase
  end

  assign cmd.kind   = kind;
  assign cmd.key    = in_key;
  assign cmd.handle = in_handle;
  assign cmd.cost   = in_cost;
  assign cmd.closed = in_closed;
  assign cmd_valid  = in_valid;
  assign in_ready   = cmd_ready;

endmodule
`default_nettype wire

[hw/rtl/solpq_queue.sv]
// Two-entry command queue between the front end and the sort engine.
`default_nettype none
module solpq_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  input  wire solpq_pkg::cmd_t wr_cmd,
  output logic                 rd_valid,
  input  wire logic            rd_ready,
  output solpq_pkg::cmd_t      rd_cmd
);

  solpq_pkg::cmd_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_wr, do_rd;

  assign wr_ready = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign rd_cmd   = slot_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = do_wr ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_rd ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/solpq_back.sv]
// Sort engine: entry stores, ordered list and the stepwise reordering sequencer.
`default_nettype none
module solpq_back #(
  parameter int CAPACITY  = 256,
  parameter int KEY_BITS  = 32,
  parameter int COST_BITS = 32
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cmd_valid,
  output logic                 cmd_ready,
  input  wire solpq_pkg::cmd_t cmd,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [1:0]           out_status,
  output logic [7:0]           out_result_handle,
  output logic                 out_hit,
  output logic                 out_top_valid,
  output logic [7:0]           out_top_handle,
  output logic [31:0]          out_top_cost,
  output logic [8:0]           out_entry_count
);

  localparam int PW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int HCW = (CW > 8) ? CW : 8;

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_POS_RD  = 15'h0002,
    S_POS_WT  = 15'h0004,
    S_DN_ORD  = 15'h0008,
    S_DN_ENT  = 15'h0010,
    S_DN_CMP  = 15'h0020,
    S_UP_ORD  = 15'h0040,
    S_UP_ENT  = 15'h0080,
    S_UP_CMP  = 15'h0100,
    S_FIN_WR  = 15'h0200,
    S_FD_CHK  = 15'h0400,
    S_FD_CMP  = 15'h0800,
    S_TOP     = 15'h1000,
    S_TOP_ENT = 15'h2000,
    S_TOP_CST = 15'h4000
  } state_t;

  state_t state_r, state_nxt;

  logic [COST_BITS-1:0] cost_mem   [CAPACITY];
  logic                 closed_mem [CAPACITY];
  logic [KEY_BITS-1:0]  key_mem    [CAPACITY];
  logic [PW-1:0]        ord_mem    [CAPACITY];
  logic [PW-1:0]        pos_mem    [CAPACITY];

  logic [COST_BITS-1:0] cost_rd_r;
  logic                 closed_rd_r;
  logic [KEY_BITS-1:0]  key_rd_r;
  logic [PW-1:0]        ord_rd_r;
  logic [PW-1:0]        pos_rd_r;

  logic [CW-1:0]        fill_r, fill_nxt;
  logic [CW-1:0]        idx_r, idx_nxt;
  logic [PW-1:0]        h_r, h_nxt;
  logic [PW-1:0]        p_r, p_nxt;
  logic                 up_r, up_nxt;
  logic [COST_BITS-1:0] cur_cost_r, cur_cost_nxt;
  logic                 cur_closed_r, cur_closed_nxt;
  logic [KEY_BITS-1:0]  find_key_r, find_key_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [7:0]           rh_r, rh_nxt;
  logic                 hit_r, hit_nxt;

  logic                 ov_r, ov_nxt;
  logic [1:0]           o_status_r, o_status_nxt;
  logic [7:0]           o_rh_r, o_rh_nxt;
  logic                 o_hit_r, o_hit_nxt;
  logic                 o_tv_r, o_tv_nxt;
  logic [7:0]           o_th_r, o_th_nxt;
  logic [31:0]          o_tc_r, o_tc_nxt;
  logic [8:0]           o_cnt_r, o_cnt_nxt;

  logic [PW-1:0]        ord_raddr, key_raddr;
  logic                 ent_we, key_we, ord_we, pos_we;
  logic [PW-1:0]        ent_waddr, ord_waddr, pos_waddr, ord_wdata, pos_wdata;
  logic [COST_BITS-1:0] ent_wcost;
  logic                 ent_wclosed;
  logic                 full, bad_handle, less_p, more_n, out_free;

  assign cmd_ready  = (state_r == S_IDLE);
  assign full       = (fill_r == CW'(CAPACITY));
  assign bad_handle = (HCW'(cmd.handle) >= HCW'(fill_r));
  assign out_free   = !ov_r || out_ready;

  // Entry p is strictly smaller than the moving entry; closed entries count as largest.
  assign less_p = !closed_rd_r && (cur_closed_r || (cost_rd_r < cur_cost_r));
  // Entry n is strictly larger than the moving entry.
  assign more_n = !cur_closed_r && (closed_rd_r || (cost_rd_r > cur_cost_r));

  always_comb begin
    unique case (state_r)
      S_DN_ORD: ord_raddr = PW'(idx_r - CW'(1));
      S_UP_ORD: ord_raddr = PW'(idx_r + CW'(1));
      default:  ord_raddr = PW'(fill_r - CW'(1));
    endcase
  end
  assign key_raddr = PW'(idx_r - CW'(1));

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    h_nxt          = h_r;
    p_nxt          = p_r;
    up_nxt         = up_r;
    cur_cost_nxt   = cur_cost_r;
    cur_closed_nxt = cur_closed_r;
    find_key_nxt   = find_key_r;
    status_nxt     = status_r;
    rh_nxt         = rh_r;
    hit_nxt        = hit_r;
    ov_nxt         = ov_r && !out_ready;
    o_status_nxt   = o_status_r;
    o_rh_nxt       = o_rh_r;
    o_hit_nxt      = o_hit_r;
    o_tv_nxt       = o_tv_r;
    o_th_nxt       = o_th_r;
    o_tc_nxt       = o_tc_r;
    o_cnt_nxt      = o_cnt_r;
    ent_we         = 1'b0;
    key_we         = 1'b0;
    ord_we         = 1'b0;
    pos_we         = 1'b0;
    ent_waddr      = PW'(fill_r);
    ent_wcost      = COST_BITS'(cmd.cost);
    ent_wclosed    = cmd.closed;
    ord_waddr      = PW'(idx_r);
    pos_waddr      = p_r;
    ord_wdata      = p_r;
    pos_wdata      = PW'(idx_r);

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          status_nxt     = solpq_pkg::ST_OK;
          rh_nxt         = 8'd0;
          hit_nxt        = 1'b0;
          cur_cost_nxt   = COST_BITS'(cmd.cost);
          cur_closed_nxt = cmd.closed;
          find_key_nxt   = KEY_BITS'(cmd.key);
          state_nxt      = S_TOP;
          case (cmd.kind) inside
            solpq_pkg::K_CLEAR: fill_nxt = '0;
            solpq_pkg::K_PUSH: begin
              if (full) begin
                status_nxt = solpq_pkg::ST_FULL;
              end else begin
                ent_we    = 1'b1;
                key_we    = 1'b1;
                h_nxt     = PW'(fill_r);
                idx_nxt   = fill_r;
                fill_nxt  = fill_r + CW'(1);
                rh_nxt    = 8'(fill_r);
                state_nxt = S_DN_ORD;
              end
            end
            solpq_pkg::K_LOWER, solpq_pkg::K_RAISE: begin
              if (bad_handle) begin
                status_nxt = solpq_pkg::ST_BAD_HNDL;
              end else begin
                ent_we    = 1'b1;
                ent_waddr = PW'(cmd.handle);
                h_nxt     = PW'(cmd.handle);
                up_nxt    = (cmd.kind == solpq_pkg::K_LOWER);
                state_nxt = S_POS_RD;
              end
            end
            solpq_pkg::K_FIND: begin
              idx_nxt   = fill_r;
              state_nxt = S_FD_CHK;
            end
            default: ;
          endcase
        end
      end
      S_POS_RD: state_nxt = S_POS_WT;
      S_POS_WT: begin
        idx_nxt   = CW'(pos_rd_r);
        state_nxt = up_r ? S_UP_ORD : S_DN_ORD;
      end
      S_DN_ORD: state_nxt = (idx_r == '0) ? S_FIN_WR : S_DN_ENT;
      S_DN_ENT: begin
        p_nxt     = ord_rd_r;
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        if (less_p) begin
          ord_we    = 1'b1;
          pos_we    = 1'b1;
          idx_nxt   = idx_r - CW'(1);
          state_nxt = S_DN_ORD;
        end else begin
          state_nxt = S_FIN_WR;
        end
      end
      S_UP_ORD: state_nxt = ((idx_r + CW'(1)) < fill_r) ? S_UP_ENT : S_FIN_WR;
      S_UP_ENT: begin
        p_nxt     = ord_rd_r;
        state_nxt = S_UP_CMP;
      end
      S_UP_CMP: begin
        if (more_n) begin
          ord_we    = 1'b1;
          pos_we    = 1'b1;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_UP_ORD;
        end else begin
          state_nxt = S_FIN_WR;
        end
      end
      S_FIN_WR: begin
        ord_we    = 1'b1;
        pos_we    = 1'b1;
        ord_wdata = h_r;
        pos_waddr = h_r;
        state_nxt = S_TOP;
      end
      S_FD_CHK: state_nxt = (idx_r == '0) ? S_TOP : S_FD_CMP;
      S_FD_CMP: begin
        if (key_rd_r == find_key_r) begin
          hit_nxt   = 1'b1;
          rh_nxt    = 8'(idx_r - CW'(1));
          state_nxt = S_TOP;
        end else begin
          idx_nxt   = idx_r - CW'(1);
          state_nxt = S_FD_CHK;
        end
      end
      S_TOP: state_nxt = (fill_r == '0) ? S_TOP_CST : S_TOP_ENT;
      S_TOP_ENT: begin
        p_nxt     = ord_rd_r;
        state_nxt = S_TOP_CST;
      end
      S_TOP_CST: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          o_status_nxt = status_r;
          o_rh_nxt     = rh_r;
          o_hit_nxt    = hit_r;
          o_cnt_nxt    = 9'(fill_r);
          if (fill_r == '0) begin
            o_tv_nxt = 1'b0;
            o_th_nxt = 8'd0;
            o_tc_nxt = 32'd0;
          end else begin
            o_tv_nxt = 1'b1;
            o_th_nxt = 8'(p_r);
            o_tc_nxt = 32'(cost_rd_r);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    h_r          <= h_nxt;
    p_r          <= p_nxt;
    up_r         <= up_nxt;
    cur_cost_r   <= cur_cost_nxt;
    cur_closed_r <= cur_closed_nxt;
    find_key_r   <= find_key_nxt;
    status_r     <= status_nxt;
    rh_r         <= rh_nxt;
    hit_r        <= hit_nxt;
    o_status_r   <= o_status_nxt;
    o_rh_r       <= o_rh_nxt;
    o_hit_r      <= o_hit_nxt;
    o_tv_r       <= o_tv_nxt;
    o_th_r       <= o_th_nxt;
    o_tc_r       <= o_tc_nxt;
    o_cnt_r      <= o_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      cost_mem[ent_waddr]   <= ent_wcost;
      closed_mem[ent_waddr] <= ent_wclosed;
    end
    cost_rd_r   <= cost_mem[ord_rd_r];
    closed_rd_r <= closed_mem[ord_rd_r];
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[PW'(fill_r)] <= KEY_BITS'(cmd.key);
    end
    key_rd_r <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    ord_rd_r <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    pos_rd_r <= pos_mem[h_r];
  end

  assign out_valid         = ov_r;
  assign out_status        = o_status_r;
  assign out_result_handle = o_rh_r;
  assign out_hit           = o_hit_r;
  assign out_top_valid     = o_tv_r;
  assign out_top_handle    = o_th_r;
  assign out_top_cost      = o_tc_r;
  assign out_entry_count   = o_cnt_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_dn_guard: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DN_CMP) |-> (idx_r != '0))
    else $error("downward move compared past the bottom");

  a_up_guard: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UP_CMP) |-> ((idx_r + CW'(1)) < fill_r))
    else $error("upward move compared past the top");

  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_ready && cmd_valid && cmd.kind == solpq_pkg::K_PUSH && !full)
      |=> (fill_r == $past(fill_r) + CW'(1)))
    else $error("accepted push did not grow the list");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> ($past(state_r) == S_TOP_CST))
    else $error("result raised outside the reporting state");

endmodule
`default_nettype wire

[hw/rtl/sorted_open_list_priority_queue.sv]
// Top level of the sorted open list priority queue.
// The list is kept fully sorted in memories: the top is the smallest-cost
// open entry, closed entries sink to the bottom. Items pass a decoder and a
// two-entry queue into a sequencer that moves an entry one position per
// step, each step being an order-list read, an entry read and a compare; an
// entry moves up to CAPACITY-1 positions, and a find scans the keys from the
// newest handle down until it hits or the list ends. The next item starts
// only when the previous one is done. Results leave through an output
// register, so the next item may enter while a result waits; a result left
// waiting holds the sequencer, and once the queue fills the input stalls.
// No clearing pass is needed after reset.
`default_nettype none
module sorted_open_list_priority_queue #(
  parameter int CAPACITY  = 256,
  parameter int KEY_BITS  = 32,
  parameter int COST_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_key,
  input  wire logic [7:0]  in_handle,
  input  wire logic [31:0] in_cost,
  input  wire logic        in_closed,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [7:0]       out_result_handle,
  output logic             out_hit,
  output logic             out_top_valid,
  output logic [7:0]       out_top_handle,
  output logic [31:0]      out_top_cost,
  output logic [8:0]       out_entry_count
);

  solpq_pkg::cmd_t f_cmd, q_cmd;
  logic            f_valid, f_ready, q_valid, q_ready;

  solpq_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_key       (in_key),
    .in_handle    (in_handle),
    .in_cost      (in_cost),
    .in_closed    (in_closed),
    .cmd_valid    (f_valid),
    .cmd_ready    (f_ready),
    .cmd          (f_cmd)
  );

  solpq_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  solpq_back #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .COST_BITS (COST_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (q_valid),
    .cmd_ready         (q_ready),
    .cmd               (q_cmd),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_result_handle (out_result_handle),
    .out_hit           (out_hit),
    .out_top_valid     (out_top_valid),
    .out_top_handle    (out_top_handle),
    .out_top_cost      (out_top_cost),
    .out_entry_count   (out_entry_count)
  );

endmodule
`default_nettype wire

[verif/solpq_checker.sv]
// Checker for the sorted open list queue: tracks list order and compares every result item.
`timescale 1ns / 1ps
module solpq_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  in_operation,
  input  wire logic [31:0] in_key,
  input  wire logic [7:0]  in_handle,
  input  wire logic [31:0] in_cost,
  input  wire logic        in_closed,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [1:0]  out_status,
  input  wire logic [7:0]  out_result_handle,
  input  wire logic        out_hit,
  input  wire logic        out_top_valid,
  input  wire logic [7:0]  out_top_handle,
  input  wire logic [31:0] out_top_cost,
  input  wire logic [8:0]  out_entry_count,
  output int               fail_count,
  output int               pending_count
);

  localparam int DEPTH = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  rhandle;
    logic        hit;
    logic        tvalid;
    logic [7:0]  thandle;
    logic [31:0] tcost;
    logic [8:0]  count;
  } queue_result_t;

  logic [31:0] cost_of [DEPTH];
  logic        closed_of [DEPTH];
  logic [31:0] key_of [DEPTH];
  logic [7:0]  order [DEPTH];
  logic [8:0]  pos_of [DEPTH];
  int          fill;
  queue_result_t expected_q[$];

  assign pending_count = expected_q.size();

  // Closed entries rank above every open entry.
  function automatic bit ranks_below(int a, int b);
    if (closed_of[a]) return 0;
    return closed_of[b] || cost_of[a] < cost_of[b];
  endfunction

  function automatic bit ranks_above(int a, int b);
    if (closed_of[b]) return 0;
    return closed_of[a] || cost_of[a] > cost_of[b];
  endfunction

  task automatic sink(int h);
    int i;
    int p;
    i = int'(pos_of[h]);
    while (i > 0) begin
      p = int'(order[i-1]);
      if (!ranks_below(p, h)) break;
      order[i] = p[7:0];
      pos_of[p] = 9'(i);
      i--;
    end
    order[i] = h[7:0];
    pos_of[h] = 9'(i);
  endtask

  task automatic rise(int h);
    int i;
    int n;
    i = int'(pos_of[h]);
    while (i + 1 < fill) begin
      n = int'(order[i+1]);
      if (!ranks_above(n, h)) break;
      order[i] = n[7:0];
      pos_of[n] = 9'(i);
      i++;
    end
    order[i] = h[7:0];
    pos_of[h] = 9'(i);
  endtask

  task automatic apply_item(logic [2:0] op, logic [31:0] key, logic [7:0] hnd,
                            logic [31:0] cost, logic cl);
    queue_result_t r;
    int h;
    int t;
    r = '0;
    r.status = solpq_pkg::ST_OK;
    case (op) inside
      solpq_pkg::OP_CLEAR: fill = 0;
      solpq_pkg::OP_PUSH: begin
        if (fill >= DEPTH) begin
          r.status = solpq_pkg::ST_FULL;
        end else begin
          h = fill;
          cost_of[h] = cost;
          closed_of[h] = cl;
          key_of[h] = key;
          order[h] = h[7:0];
          pos_of[h] = 9'(h);
          fill++;
          sink(h);
          r.rhandle = h[7:0];
        end
      end
      solpq_pkg::OP_LOWER, solpq_pkg::OP_RAISE: begin
        if (int'(hnd) >= fill) begin
          r.status = solpq_pkg::ST_BAD_HNDL;
        end else begin
          cost_of[hnd] = cost;
          closed_of[hnd] = cl;
          if (op == solpq_pkg::OP_LOWER) rise(int'(hnd));
          else sink(int'(hnd));
        end
      end
      solpq_pkg::OP_FIND: begin
        for (int i = fill - 1; i >= 0; i--) begin
          if (key_of[i] == key) begin
            r.hit = 1;
            r.rhandle = i[7:0];
            break;
          end
        end
      end
      default: ;
    endcase
    if (fill > 0) begin
      t = int'(order[fill-1]);
      r.tvalid = 1;
      r.thandle = t[7:0];
      r.tcost = cost_of[t];
    end
    r.count = fill[8:0];
    expected_q = {expected_q, r};
  endtask

  always @(posedge clk) begin
    queue_result_t e;
    if (!rst_n) begin
      fill = 0;
      fail_count = 0;
      expected_q.delete();
    end else begin
      if (in_valid && in_ready)
        apply_item(in_operation, in_key, in_handle, in_cost, in_closed);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected");
          fail_count++;
        end else begin
          e = expected_q.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); fail_count++;
          end
          if (out_result_handle !== e.rhandle) begin
            $error("result_handle exp %0d got %0d", e.rhandle, out_result_handle);
            fail_count++;
          end
          if (out_hit !== e.hit) begin
            $error("hit exp %0d got %0d", e.hit, out_hit); fail_count++;
          end
          if (out_top_valid !== e.tvalid) begin
            $error("top_valid exp %0d got %0d", e.tvalid, out_top_valid); fail_count++;
          end
          if (out_top_handle !== e.thandle) begin
            $error("top_handle exp %0d got %0d", e.thandle, out_top_handle);
            fail_count++;
          end
          if (out_top_cost !== e.tcost) begin
            $error("top_cost exp %0h got %0h", e.tcost, out_top_cost); fail_count++;
          end
          if (out_entry_count !== e.count) begin
            $error("entry_count exp %0d got %0d", e.count, out_entry_count);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

[verif/tb_sorted_open_list_priority_queue.sv]
// Testbench top for the sorted open list queue: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_sorted_open_list_priority_queue;

  localparam int CYCLE_LIMIT = 8000000;
  // First of the three operation codes that the block ignores.
  localparam logic [2:0] OP_SPARE = 3'd5;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_ready;
  logic [2:0]  in_operation = solpq_pkg::OP_CLEAR;
  logic [31:0] in_key = '0;
  logic [7:0]  in_handle = '0;
  logic [31:0] in_cost = '0;
  logic        in_closed = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [1:0]  out_status;
  logic [7:0]  out_result_handle;
  logic        out_hit;
  logic        out_top_valid;
  logic [7:0]  out_top_handle;
  logic [31:0] out_top_cost;
  logic [8:0]  out_entry_count;
  int          fail_count;
  int          pending_count;
  int          cycle_count = 0;
  bit          calm = 0;
  int          list_size = 0;
  logic [31:0] recent_keys [8] = '{default: '0};

  always #2 clk = ~clk;

  sorted_open_list_priority_queue u_top (.*);

  solpq_checker u_check (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk)
    out_ready <= !rst_n ? 1'b0 : (calm || $urandom_range(99) >= 29);

  // One item: optional idle gap, then hold valid until accepted.
  // Called and returning at a falling edge; valid is left high on return.
  task automatic send(logic [2:0] op, logic [31:0] key, logic [7:0] hnd,
                      logic [31:0] cost, logic cl);
    while (!calm && $urandom_range(99) < 29) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_key <= key;
    in_handle <= hnd;
    in_cost <= cost;
    in_closed <= cl;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    case (op)
      solpq_pkg::OP_CLEAR: list_size = 0;
      solpq_pkg::OP_PUSH: begin
        if (list_size < 256) begin
          recent_keys[list_size % 8] = key;
          list_size++;
        end
      end
      default: ;
    endcase
  endtask

  function automatic logic [31:0] rand_cost();
    case ($urandom_range(3))
      0: return 32'($urandom_range(15));
      1: return 32'hFFFF_FFF0 | 32'($urandom_range(15));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [7:0] rand_handle();
    if (list_size > 0 && $urandom_range(9) != 0) return 8'($urandom_range(list_size - 1));
    return 8'($urandom_range(255));
  endfunction

  initial begin
    int sel;
    int k;
    logic [31:0] key;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Empty list: find, updates of missing handles, unused codes.
    send(solpq_pkg::OP_FIND, 32'd0, 8'd0, 32'd0, 1'b0);
    send(solpq_pkg::OP_LOWER, 32'd0, 8'd0, 32'd1, 1'b0);
    send(solpq_pkg::OP_RAISE, 32'd0, 8'd255, 32'd1, 1'b1);
    for (k = 0; k < 3; k++)
      send(OP_SPARE + 3'(k), 32'hFFFF_FFFF, 8'd7, 32'd9, 1'b1);
    send(solpq_pkg::OP_CLEAR, 32'd0, 8'd0, 32'd0, 1'b0);

    // Extremes, ties and closed entries.
    send(solpq_pkg::OP_PUSH, 32'd10, 8'd0, 32'd0, 1'b0);
    send(solpq_pkg::OP_PUSH, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF, 1'b0);
    send(solpq_pkg::OP_PUSH, 32'd10, 8'd0, 32'd7, 1'b0);
    send(solpq_pkg::OP_PUSH, 32'd11, 8'd0, 32'd7, 1'b0);
    send(solpq_pkg::OP_PUSH, 32'd12, 8'd0, 32'd0, 1'b1);
    send(solpq_pkg::OP_PUSH, 32'd13, 8'd0, 32'd0, 1'b0);
    send(solpq_pkg::OP_FIND, 32'd10, 8'd0, 32'd0, 1'b0);
    send(solpq_pkg::OP_FIND, 32'hFFFF_FFFF, 8'd0, 32'd0, 1'b0);
    send(solpq_pkg::OP_FIND, 32'd99, 8'd0, 32'd0, 1'b0);
    send(solpq_pkg::OP_LOWER, 32'd0, 8'd1, 32'd0, 1'b0);
    send(solpq_pkg::OP_RAISE, 32'd0, 8'd5, 32'hFFFF_FFFF, 1'b0);
    send(solpq_pkg::OP_RAISE, 32'd0, 8'd1, 32'd3, 1'b1);
    // Lower with a higher cost and raise with a lower cost.
    send(solpq_pkg::OP_LOWER, 32'd0, 8'd0, 32'd100, 1'b0);
    send(solpq_pkg::OP_RAISE, 32'd0, 8'd3, 32'd1, 1'b0);
    send(solpq_pkg::OP_LOWER, 32'd0, 8'd6, 32'd1, 1'b0);
    for (k = 0; k < 6; k++)
      send(solpq_pkg::OP_RAISE, 32'd0, 8'(k), 32'(k), 1'b1);
    send(solpq_pkg::OP_LOWER, 32'd0, 8'd2, 32'd5, 1'b0);
    send(solpq_pkg::OP_CLEAR, 32'd0, 8'd0, 32'd0, 1'b0);
    send(solpq_pkg::OP_FIND, 32'd10, 8'd0, 32'd0, 1'b0);

    // Fill the list to capacity with no idling, then work on the full list.
    calm = 1;
    for (k = 0; k < 257; k++)
      send(solpq_pkg::OP_PUSH, 32'($urandom_range(31)), 8'd0, rand_cost(),
           $urandom_range(9) == 0);
    for (k = 0; k < 40; k++)
      send(($urandom_range(1) == 0) ? solpq_pkg::OP_LOWER : solpq_pkg::OP_RAISE,
           $urandom(), rand_handle(), rand_cost(), $urandom_range(5) == 0);
    for (k = 0; k < 10; k++)
      send(solpq_pkg::OP_FIND, 32'($urandom_range(40)), 8'd0, 32'd0, 1'b0);
    calm = 0;
    send(solpq_pkg::OP_CLEAR, 32'd0, 8'd0, 32'd0, 1'b0);

    // Random mix.
    for (k = 0; k < 1010; k++) begin
      sel = $urandom_range(99);
      key = ($urandom_range(1) == 0) ? 32'($urandom_range(15)) : $urandom();
      if (sel < 2) begin
        send(solpq_pkg::OP_CLEAR, key, 8'd0, 32'd0, 1'b0);
      end else if (sel < 5) begin
        send(OP_SPARE + 3'($urandom_range(2)), key, rand_handle(), rand_cost(), 1'b0);
      end else if (sel < 40) begin
        send(solpq_pkg::OP_PUSH, key, 8'd0, rand_cost(), $urandom_range(7) == 0);
      end else if (sel < 60) begin
        send(solpq_pkg::OP_LOWER, key, rand_handle(), rand_cost(), $urandom_range(9) == 0);
      end else if (sel < 80) begin
        send(solpq_pkg::OP_RAISE, key, rand_handle(), rand_cost(), $urandom_range(3) == 0);
      end else begin
        if ($urandom_range(3) != 0) key = recent_keys[$urandom_range(7)];
        send(solpq_pkg::OP_FIND, key, 8'd0, 32'd0, 1'b0);
      end
    end

    in_valid <= 1'b0;
    wait (pending_count == 0);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
